@@ rtl/subset_sum_selector_core_defines.svh @@
// ----------------------------------------------------------------------------
// subset_sum_selector_core_defines.svh
// Assertion macros shared by the subset-sum selector RTL.
// ----------------------------------------------------------------------------
`ifndef SUBSET_SUM_SELECTOR_CORE_DEFINES_SVH
`define SUBSET_SUM_SELECTOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication check.
`define SSUM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication check.
`define SSUM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SSUM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define SSUM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/ssum_pkg.sv @@
// ----------------------------------------------------------------------------
// ssum_pkg
// Sizes, state codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssum_pkg;

   localparam int MAX_ITEMS    = 32;
   localparam int MAX_CAPACITY = 256;

   localparam int FIELD_W = 8;
   localparam int CAP_W   = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
   localparam int IDX_W   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int COUNT_W = $clog2(MAX_ITEMS + 1);
   localparam int CMP_W   = ((CAP_W > FIELD_W) ? CAP_W : FIELD_W) + 1;

   localparam int TAKE_DEPTH = MAX_ITEMS * (2 ** CAP_W);
   localparam int TAKE_AW    = (TAKE_DEPTH > 1) ? $clog2(TAKE_DEPTH) : 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROW_RD,
      ST_ROW_LD,
      ST_SWEEP,
      ST_DRAIN,
      ST_SUM_RD,
      ST_SUM_LD,
      ST_BT_CHK,
      ST_BT_EV,
      ST_EM_SCAN,
      ST_EM_LD,
      ST_EM_OUT
   } ssum_state_type;

   typedef struct packed {
      logic store;     // write incoming item
      logic row_init;  // item row index to zero
      logic load_w;    // latch row weight, column to capacity
      logic sweep;     // issue one table cell, step column down
      logic next_row;  // advance item row
      logic sum_rd;    // read best sum at capacity
      logic bt_init;   // latch sum, arm backtrack
      logic bt_rd;     // read take bit and weight of row below
      logic bt_eval;   // apply one backtrack step
      logic em_init;   // arm emission scan
      logic em_skip;   // skip an unpicked item
      logic em_load;   // load result register
      logic em_next;   // result taken, move on
      logic clear;     // drop the finished set
   } ssum_cmd_type;

   typedef struct packed {
      logic cap_zero;
      logic col_one;
      logic row_last;
      logic bt_done;
      logic picked_here;
      logic none_picked;
      logic out_last;
   } ssum_sts_type;

   // Capacity register saturated to the table width.
   function automatic logic [CAP_W-1:0] eff_cap(input logic [FIELD_W-1:0] c);
      if (32'(c) > 32'(MAX_CAPACITY - 1)) begin
         return CAP_W'(MAX_CAPACITY - 1);
      end
      return CAP_W'(c);
   endfunction

endpackage

`default_nettype wire

@@ rtl/subset_sum_selector_core.sv @@
// ----------------------------------------------------------------------------
// subset_sum_selector_core
// 0/1 subset-sum core selector under a configurable wire budget.
// ----------------------------------------------------------------------------
// Items (wire width, core id) stream in one per cycle while the block is idle;
// the transfer carrying tlast closes the set and starts the solve. Up to 32
// items are kept, later ones are dropped and flagged in every result of that
// run. Unless the capacity is zero, the solve sweeps the best-sum row once per
// stored item, from the capacity column down to column one, resolving one cell
// per clock through a dual-read best-sum memory and a 1-bit take table (32 x
// 256 cells). The backtrack then walks the item rows down from the last one,
// and emission scans items in ascending order, waiting on the consumer for
// each result. Results carry the chosen core ids in ascending item order, each
// with the achieved sum; an empty selection gives one result with none_chosen
// set. Intake is closed from the closing transfer until the last result of the
// run is taken. The capacity register is written through csr_we/csr_wdata; the
// user must write it only while idle, the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module subset_sum_selector_core (
   input  wire logic        clock,
   input  wire logic        reset,

   // item input
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] item_width, [15:8] core_id
   input  wire logic        req_tlast,   // is_last_item

   // result output
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // [7:0] chosen_core, [15:8] achieved_sum
   output logic      [1:0]  rsp_tuser,   // [0] none_chosen, [1] items_dropped
   output logic             rsp_tlast,   // last_result

   // capacity register
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_wdata
);

   import ssum_pkg::*;

   ssum_cmd_type cmd;
   ssum_sts_type sts;

   logic [7:0] out_core;
   logic [7:0] out_sum;
   logic       out_none;
   logic       out_dropped;
   logic       out_last;

   // sequencer: owns the handshakes, steps the datapath
   ssum_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // item store, DP table, backtrack and result register
   ssum_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_tdata   (req_tdata),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .out_core    (out_core),
      .out_sum     (out_sum),
      .out_none    (out_none),
      .out_dropped (out_dropped),
      .out_last    (out_last)
   );

   // result transfer fields, held in registers through the wait
   assign rsp_tdata = {out_sum, out_core};
   assign rsp_tuser = {out_dropped, out_none};
   assign rsp_tlast = out_last;

endmodule

`default_nettype wire

@@ rtl/ssum_ram.sv @@
// ----------------------------------------------------------------------------
// ssum_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssum_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/ssum_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssum_ctrl
// Sequencer: intake, table sweep, backtrack and result emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssum_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tlast,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire ssum_pkg::ssum_sts_type sts,
   output ssum_pkg::ssum_cmd_type     cmd
);

   import ssum_pkg::*;

`include "subset_sum_selector_core_defines.svh"

   ssum_state_type state_ff;
   ssum_state_type state_in;
   logic           req_xfer;

   assign req_xfer = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tlast) begin
               state_in = sts.cap_zero ? ST_SUM_RD : ST_ROW_RD;
            end
         end
         ST_ROW_RD:  state_in = ST_ROW_LD;
         ST_ROW_LD:  state_in = ST_SWEEP;
         ST_SWEEP: begin
            if (sts.col_one) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:   state_in = sts.row_last ? ST_SUM_RD : ST_ROW_RD;
         ST_SUM_RD:  state_in = ST_SUM_LD;
         ST_SUM_LD:  state_in = ST_BT_CHK;
         ST_BT_CHK:  state_in = sts.bt_done ? ST_EM_SCAN : ST_BT_EV;
         ST_BT_EV:   state_in = ST_BT_CHK;
         ST_EM_SCAN: begin
            if (sts.none_picked || sts.picked_here) begin
               state_in = ST_EM_LD;
            end
         end
         ST_EM_LD:   state_in = ST_EM_OUT;
         ST_EM_OUT: begin
            if (rsp_tready) begin
               state_in = sts.out_last ? ST_IDLE : ST_EM_SCAN;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.store    = req_xfer;
            cmd.row_init = req_xfer && req_tlast;
         end
         ST_ROW_RD:  ;
         ST_ROW_LD:  cmd.load_w = 1'b1;
         ST_SWEEP:   cmd.sweep = 1'b1;
         ST_DRAIN:   cmd.next_row = !sts.row_last;
         ST_SUM_RD:  cmd.sum_rd = 1'b1;
         ST_SUM_LD:  cmd.bt_init = 1'b1;
         ST_BT_CHK: begin
            cmd.bt_rd   = !sts.bt_done;
            cmd.em_init = sts.bt_done;
         end
         ST_BT_EV:   cmd.bt_eval = 1'b1;
         ST_EM_SCAN: cmd.em_skip = !sts.none_picked && !sts.picked_here;
         ST_EM_LD:   cmd.em_load = 1'b1;
         ST_EM_OUT: begin
            rsp_tvalid  = 1'b1;
            cmd.em_next = rsp_tready && !sts.out_last;
            cmd.clear   = rsp_tready && sts.out_last;
         end
         default:    ;
      endcase
   end

   `SSUM_ASSERT_IMPL(a_ready_valid_excl, clock, reset, req_tready, !rsp_tvalid, "intake open while a result is offered")
   `SSUM_ASSERT_NEXT(a_busy_after_last, clock, reset, req_xfer && req_tlast, !req_tready, "intake still open after the closing item")
   `SSUM_ASSERT_IMPL(a_sweep_nonzero_cap, clock, reset, state_ff == ST_SWEEP, !sts.cap_zero, "table sweep with zero capacity")

endmodule

`default_nettype wire

@@ rtl/ssum_dpath.sv @@
// ----------------------------------------------------------------------------
// ssum_dpath
// Item store, best-sum row, take-bit table, backtrack and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssum_dpath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ssum_pkg::ssum_cmd_type cmd,
   output ssum_pkg::ssum_sts_type      sts,
   input  wire logic [15:0]            req_tdata,
   input  wire logic                   csr_we,
   input  wire logic [7:0]             csr_wdata,
   output logic      [7:0]             out_core,
   output logic      [7:0]             out_sum,
   output logic                        out_none,
   output logic                        out_dropped,
   output logic                        out_last
);

   import ssum_pkg::*;

`include "subset_sum_selector_core_defines.svh"

   // configuration
   logic [FIELD_W-1:0] capacity_ff;
   logic [CAP_W-1:0]   cap;

   // set bookkeeping
   logic [COUNT_W-1:0] item_cnt_ff, item_cnt_in;
   logic               overflow_ff, overflow_in;
   logic               full;

   // shared counters
   logic [COUNT_W-1:0] itm_ff, itm_in;
   logic [COUNT_W-1:0] itm_dec;
   logic [CAP_W-1:0]   col_ff, col_in;
   logic [FIELD_W-1:0] w_ff;

   // sweep stage
   logic               s_valid_ff;
   logic [CAP_W-1:0]   s_col_ff;
   logic               s_fit_ff;
   logic               s_lo_zero_ff;
   logic               s_row0_ff;
   logic [CMP_W-1:0]   lo_diff;
   logic [CAP_W-1:0]   hi_eff, lo_eff, best_new;
   logic [CMP_W-1:0]   cand;
   logic               take;

   // backtrack / emission
   logic [CAP_W-1:0]     sum_ff;
   logic [MAX_ITEMS-1:0] picked_ff, picked_in;
   logic [COUNT_W-1:0]   pick_cnt_ff, pick_cnt_in;
   logic [COUNT_W-1:0]   em_cnt_ff, em_cnt_in;
   logic [7:0]           out_core_ff;
   logic                 out_none_ff, out_last_ff;

   // memory ports
   logic [IDX_W-1:0]   item_wr_addr, width_rd_addr;
   logic [FIELD_W-1:0] width_rd, core_rd;
   logic [CAP_W-1:0]   best_a_addr;
   logic [CAP_W-1:0]   best_a_rd, best_b_rd;
   logic [TAKE_AW-1:0] take_wr_addr, take_rd_addr;
   logic               take_rd;

   assign cap     = eff_cap(capacity_ff);
   assign full    = (item_cnt_ff == COUNT_W'(MAX_ITEMS));
   assign itm_dec = itm_ff - COUNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '0;
      end else if (csr_we) begin
         capacity_ff <= csr_wdata;
      end
   end

   // ---- item store ----
   assign item_wr_addr  = item_cnt_ff[IDX_W-1:0];
   assign width_rd_addr = cmd.bt_rd ? itm_dec[IDX_W-1:0] : itm_ff[IDX_W-1:0];

   ssum_ram #(.WIDTH(FIELD_W), .DEPTH(MAX_ITEMS)) u_width_ram (
      .clock   (clock),
      .wr_en   (cmd.store && !full),
      .wr_addr (item_wr_addr),
      .wr_data (req_tdata[7:0]),
      .rd_addr (width_rd_addr),
      .rd_data (width_rd)
   );

   ssum_ram #(.WIDTH(FIELD_W), .DEPTH(MAX_ITEMS)) u_core_ram (
      .clock   (clock),
      .wr_en   (cmd.store && !full),
      .wr_addr (item_wr_addr),
      .wr_data (req_tdata[15:8]),
      .rd_addr (itm_ff[IDX_W-1:0]),
      .rd_data (core_rd)
   );

   always_comb begin
      item_cnt_in = item_cnt_ff;
      overflow_in = overflow_ff;
      if (cmd.clear) begin
         item_cnt_in = '0;
         overflow_in = 1'b0;
      end else if (cmd.store) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            item_cnt_in = item_cnt_ff + COUNT_W'(1);
         end
      end
   end

   // ---- table sweep: issue cell at col_ff, resolve it in the next cycle ----
   assign lo_diff     = CMP_W'(col_ff) - CMP_W'(w_ff);
   assign best_a_addr = cmd.sum_rd ? cap : col_ff;

   // row zero sees a cleared row; column zero of the row is always zero
   assign hi_eff   = s_row0_ff ? '0 : best_a_rd;
   assign lo_eff   = (s_row0_ff || s_lo_zero_ff) ? '0 : best_b_rd;
   assign cand     = CMP_W'(w_ff) + CMP_W'(lo_eff);
   assign take     = s_fit_ff && (CMP_W'(hi_eff) < cand);
   assign best_new = take ? cand[CAP_W-1:0] : hi_eff;

   ssum_ram #(.WIDTH(CAP_W), .DEPTH(MAX_CAPACITY)) u_best_a_ram (
      .clock   (clock),
      .wr_en   (s_valid_ff),
      .wr_addr (s_col_ff),
      .wr_data (best_new),
      .rd_addr (best_a_addr),
      .rd_data (best_a_rd)
   );

   ssum_ram #(.WIDTH(CAP_W), .DEPTH(MAX_CAPACITY)) u_best_b_ram (
      .clock   (clock),
      .wr_en   (s_valid_ff),
      .wr_addr (s_col_ff),
      .wr_data (best_new),
      .rd_addr (lo_diff[CAP_W-1:0]),
      .rd_data (best_b_rd)
   );

   assign take_wr_addr = TAKE_AW'({itm_ff[IDX_W-1:0], s_col_ff});
   assign take_rd_addr = TAKE_AW'({itm_dec[IDX_W-1:0], col_ff});

   ssum_ram #(.WIDTH(1), .DEPTH(TAKE_DEPTH)) u_take_ram (
      .clock   (clock),
      .wr_en   (s_valid_ff),
      .wr_addr (take_wr_addr),
      .wr_data (take),
      .rd_addr (take_rd_addr),
      .rd_data (take_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= cmd.sweep;
      end
   end

   always_ff @(posedge clock) begin
      s_col_ff     <= col_ff;
      s_fit_ff     <= (CMP_W'(w_ff) <= CMP_W'(col_ff));
      s_lo_zero_ff <= (lo_diff == '0);
      s_row0_ff    <= (itm_ff == '0);
      if (cmd.load_w) begin
         w_ff <= width_rd;
      end
      if (cmd.bt_init) begin
         sum_ff <= (cap == '0) ? '0 : best_a_rd;
      end
   end

   // ---- shared item / column counters ----
   always_comb begin
      itm_in = itm_ff;
      col_in = col_ff;
      if (cmd.row_init || cmd.em_init) begin
         itm_in = '0;
      end else if (cmd.next_row || cmd.em_skip || cmd.em_next) begin
         itm_in = itm_ff + COUNT_W'(1);
      end else if (cmd.bt_init) begin
         itm_in = item_cnt_ff;
      end else if (cmd.bt_eval) begin
         itm_in = itm_dec;
      end

      if (cmd.load_w || cmd.bt_init) begin
         col_in = cap;
      end else if (cmd.sweep) begin
         col_in = col_ff - CAP_W'(1);
      end else if (cmd.bt_eval && take_rd) begin
         col_in = CAP_W'(CMP_W'(col_ff) - CMP_W'(width_rd));
      end
   end

   // ---- backtrack picks and emission ----
   always_comb begin
      picked_in   = picked_ff;
      pick_cnt_in = pick_cnt_ff;
      em_cnt_in   = em_cnt_ff;
      if (cmd.bt_init || cmd.clear) begin
         picked_in   = '0;
         pick_cnt_in = '0;
      end else if (cmd.bt_eval && take_rd) begin
         picked_in[itm_dec[IDX_W-1:0]] = 1'b1;
         pick_cnt_in = pick_cnt_ff + COUNT_W'(1);
      end
      if (cmd.em_init) begin
         em_cnt_in = '0;
      end else if (cmd.em_next) begin
         em_cnt_in = em_cnt_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_cnt_ff <= '0;
         overflow_ff <= 1'b0;
         itm_ff      <= '0;
         col_ff      <= '0;
         picked_ff   <= '0;
         pick_cnt_ff <= '0;
         em_cnt_ff   <= '0;
      end else begin
         item_cnt_ff <= item_cnt_in;
         overflow_ff <= overflow_in;
         itm_ff      <= itm_in;
         col_ff      <= col_in;
         picked_ff   <= picked_in;
         pick_cnt_ff <= pick_cnt_in;
         em_cnt_ff   <= em_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.em_load) begin
         out_core_ff <= sts.none_picked ? '0 : core_rd;
         out_none_ff <= sts.none_picked;
         out_last_ff <= sts.none_picked || (em_cnt_ff + COUNT_W'(1) == pick_cnt_ff);
      end
   end

   assign out_core    = out_core_ff;
   assign out_sum     = 8'(sum_ff);
   assign out_none    = out_none_ff;
   assign out_dropped = overflow_ff;
   assign out_last    = out_last_ff;

   // ---- status ----
   assign sts.cap_zero    = (cap == '0);
   assign sts.col_one     = (col_ff == CAP_W'(1));
   assign sts.row_last    = (itm_ff + COUNT_W'(1) == item_cnt_ff);
   assign sts.bt_done     = (itm_ff == '0) || (col_ff == '0);
   assign sts.picked_here = picked_ff[itm_ff[IDX_W-1:0]];
   assign sts.none_picked = (pick_cnt_ff == '0);
   assign sts.out_last    = out_last_ff;

   `SSUM_ASSERT_IMPL(a_best_le_col, clock, reset, s_valid_ff, best_new <= s_col_ff, "best sum above its column")
   `SSUM_ASSERT_IMPL(a_picks_bounded, clock, reset, 1'b1, pick_cnt_ff <= item_cnt_ff, "more picks than stored items")
   `SSUM_ASSERT_NEXT(a_bt_col_down, clock, reset, cmd.bt_eval && take_rd, col_ff <= $past(col_ff), "backtrack column grew")

endmodule

`default_nettype wire
